// ===== rtl/core/dlp_pkg.sv =====
// Shared types and constants of the delimiter line pager.
package dlp_pkg;

	localparam int BYTE_W     = 8;
	localparam int IN_POS_W   = 32;
	localparam int OUT_W      = 32;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int LINES_W    = 7;

	localparam logic [CFG_IDX_W-1:0] REG_PAGE_LINES    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DELIMITER     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BACKWARD_MODE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FILE_LENGTH   = 2'd3;

	localparam logic [LINES_W-1:0] PAGE_LINES_RST = 7'd64;
	localparam logic [BYTE_W-1:0]  DELIMITER_RST  = 8'd10;

	localparam logic OP_DATA = 1'b0;
	localparam logic OP_EOS  = 1'b1;

	typedef struct packed {
		logic             page_end;
		logic [OUT_W-1:0] length;
		logic [OUT_W-1:0] start;
	} piece_t;

	typedef struct packed {
		logic take_item;
		logic emit_entry;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_flush;
		logic last_entry;
		logic fill_nz;
	} dp_status_t;

endpackage

// ===== rtl/core/dlp_out_queue.sv =====
// Two-entry result queue between the pager core and the output stream.
module dlp_out_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  dlp_pkg::piece_t push_data,
	output logic            full,
	output logic            out_valid,
	input  logic            out_ready,
	output dlp_pkg::piece_t out_data
);

	dlp_pkg::piece_t entry0_q;
	dlp_pkg::piece_t entry1_q;
	logic [1:0]      count_q;
	logic            pop;

	assign pop       = out_valid && out_ready;
	assign full      = (count_q == 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_data  = entry0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (push && !pop) begin
			count_q <= count_q + 2'd1;
		end else if (pop && !push) begin
			count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !pop) begin
			if (count_q == 2'd0) begin
				entry0_q <= push_data;
			end else begin
				entry1_q <= push_data;
			end
		end else if (pop && !push) begin
			entry0_q <= entry1_q;
		end else if (pop && push) begin
			if (count_q == 2'd1) begin
				entry0_q <= push_data;
			end else begin
				entry0_q <= entry1_q;
				entry1_q <= push_data;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("result queue count out of range");

endmodule

// ===== rtl/core/dlp_ctrl.sv =====
// Controller state machine: item acceptance and segment flush sequencing.
module dlp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic                q_full,
	input  dlp_pkg::dp_status_t status,
	output dlp_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE    = 3'b001,
		S_FL_READ = 3'b010,
		S_FL_EMIT = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		s_tready       = (state_q == S_IDLE) && !q_full;
		cmd.take_item  = s_tready && s_tvalid;
		cmd.emit_entry = (state_q == S_FL_EMIT) && !q_full;
		state_d        = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.take_item && status.need_flush) begin
					state_d = S_FL_READ;
				end
			end
			S_FL_READ: begin
				state_d = S_FL_EMIT;
			end
			S_FL_EMIT: begin
				if (cmd.emit_entry) begin
					state_d = status.last_entry ? S_IDLE : S_FL_READ;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_emit_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_entry |-> !q_full)
		else $error("segment emitted into a full queue");

	a_flush_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> status.fill_nz)
		else $error("flush running with an empty segment store");

	a_last_ends_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_entry && status.last_entry) |=> (state_q == S_IDLE))
		else $error("flush did not end after its last segment");

endmodule

// ===== rtl/core/dlp_datapath.sv =====
// Datapath: configuration registers, scan state, segment store and piece forming.
module dlp_datapath #(
	parameter int MAX_PAGE_LINES = 64,
	parameter int POS_BITS       = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [dlp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [dlp_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 in_opcode,
	input  logic [dlp_pkg::BYTE_W-1:0]           in_byte,
	input  logic [dlp_pkg::IN_POS_W-1:0]         in_pos,
	input  dlp_pkg::ctrl_cmd_t                   cmd,
	output dlp_pkg::dp_status_t                  status,
	output logic                                 push,
	output dlp_pkg::piece_t                      push_data
);

	localparam int PW = POS_BITS;
	localparam int FW = $clog2(MAX_PAGE_LINES + 1);
	localparam int AW = (MAX_PAGE_LINES > 1) ? $clog2(MAX_PAGE_LINES) : 1;
	localparam int LW = dlp_pkg::LINES_W;
	localparam logic [LW-1:0] MAX_LINES = LW'(MAX_PAGE_LINES);
	localparam logic [FW-1:0] FILL_MAX  = FW'(MAX_PAGE_LINES);

	// Configuration registers.
	logic [LW-1:0]                  page_lines_q;
	logic [dlp_pkg::BYTE_W-1:0]     delimiter_q;
	logic                           backward_q;
	logic [dlp_pkg::CFG_DATA_W-1:0] file_length_q;

	// Scan state.
	logic [LW-1:0] line_count_q;
	logic [PW-1:0] page_begin_q;
	logic          last_delim_q;
	logic [PW-1:0] seg_stop_q;
	logic          scan_open_q;
	logic [FW-1:0] fill_q;
	logic [FW-1:0] rd_idx_q;

	logic [2*PW-1:0] seg_mem [MAX_PAGE_LINES];
	logic [2*PW-1:0] rd_data_q;

	logic [PW-1:0]   size;
	logic [PW-1:0]   pos;
	logic [PW:0]     pos_inc;
	logic [PW-1:0]   seg_stop_cur;
	logic [LW-1:0]   lines_pp;
	logic [LW-1:0]   lc_inc;
	logic [FW-1:0]   fill_inc;
	logic            is_data;
	logic            is_eos;
	logic            is_delim;
	logic            in_file;
	logic            size_zero;
	logic            fwd_delim;
	logic            bwd_delim;
	logic            page_full;
	logic            bwd_close;
	logic            store_room;
	logic            mem_we;
	logic [2*PW-1:0] mem_wdata;
	logic            direct_push;
	dlp_pkg::piece_t direct_piece;
	dlp_pkg::piece_t entry_piece;
	logic [PW-1:0]   ent_start;
	logic [PW-1:0]   ent_stop;

	always_comb begin
		size         = PW'(file_length_q);
		pos          = PW'(in_pos);
		pos_inc      = {1'b0, pos} + {{PW{1'b0}}, 1'b1};
		seg_stop_cur = scan_open_q ? seg_stop_q : size;
		if (page_lines_q == '0) begin
			lines_pp = LW'(1);
		end else if (page_lines_q > MAX_LINES) begin
			lines_pp = MAX_LINES;
		end else begin
			lines_pp = page_lines_q;
		end
		store_room = (fill_q < FILL_MAX);
		fill_inc   = store_room ? fill_q + FW'(1) : fill_q;
		lc_inc     = line_count_q + LW'(1);
		page_full  = (lc_inc >= lines_pp);
		is_data    = (in_opcode == dlp_pkg::OP_DATA);
		is_eos     = (in_opcode == dlp_pkg::OP_EOS);
		is_delim   = (in_byte == delimiter_q);
		in_file    = (pos < size);
		size_zero  = (size == '0);
		fwd_delim  = is_data && in_file && is_delim && !backward_q;
		bwd_delim  = is_data && in_file && is_delim && backward_q;
		bwd_close  = is_eos && !size_zero && backward_q;

		mem_we    = cmd.take_item && (bwd_delim || bwd_close) && store_room;
		mem_wdata = {bwd_delim ? pos_inc[PW-1:0] : {PW{1'b0}}, seg_stop_cur};

		// A result produced straight from the accepted item.
		direct_push  = 1'b0;
		direct_piece = '{page_end: 1'b1, length: '0, start: '0};
		if (fwd_delim && page_full && (pos >= page_begin_q)) begin
			direct_push        = 1'b1;
			direct_piece.start  = dlp_pkg::OUT_W'(page_begin_q);
			direct_piece.length = dlp_pkg::OUT_W'(pos - page_begin_q);
		end else if (is_eos && size_zero) begin
			direct_push = 1'b1;
		end else if (is_eos && !backward_q) begin
			if (page_begin_q < size) begin
				direct_push        = 1'b1;
				direct_piece.start  = dlp_pkg::OUT_W'(page_begin_q);
				direct_piece.length = dlp_pkg::OUT_W'(size - page_begin_q);
			end else if (last_delim_q) begin
				direct_push = 1'b1;
			end
		end

		status.need_flush = (bwd_delim && (8'(fill_inc) >= 8'(lines_pp))) || bwd_close;
		status.last_entry = (FW'(rd_idx_q + FW'(1)) == fill_q);
		status.fill_nz    = (fill_q != '0);

		// Stored segments are (start, stop) with start in the upper half.
		ent_start          = rd_data_q[2*PW-1:PW];
		ent_stop           = rd_data_q[PW-1:0];
		entry_piece.start  = dlp_pkg::OUT_W'(ent_start);
		entry_piece.length = (ent_stop >= ent_start) ?
			dlp_pkg::OUT_W'(ent_stop - ent_start) : '0;
		entry_piece.page_end = status.last_entry;

		push      = (cmd.take_item && direct_push) || cmd.emit_entry;
		push_data = cmd.emit_entry ? entry_piece : direct_piece;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_lines_q  <= dlp_pkg::PAGE_LINES_RST;
			delimiter_q   <= dlp_pkg::DELIMITER_RST;
			backward_q    <= 1'b0;
			file_length_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dlp_pkg::REG_PAGE_LINES:    page_lines_q  <= cfg_data[LW-1:0];
				dlp_pkg::REG_DELIMITER:     delimiter_q   <= cfg_data[dlp_pkg::BYTE_W-1:0];
				dlp_pkg::REG_BACKWARD_MODE: backward_q    <= cfg_data[0];
				dlp_pkg::REG_FILE_LENGTH:   file_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_count_q <= '0;
			page_begin_q <= '0;
			last_delim_q <= 1'b0;
			seg_stop_q   <= '0;
			scan_open_q  <= 1'b0;
			fill_q       <= '0;
			rd_idx_q     <= '0;
		end else if (cmd.take_item) begin
			rd_idx_q <= '0;
			if (is_eos) begin
				line_count_q <= '0;
				page_begin_q <= '0;
				last_delim_q <= 1'b0;
				scan_open_q  <= 1'b0;
				fill_q       <= bwd_close ? fill_inc : '0;
			end else begin
				scan_open_q <= 1'b1;
				seg_stop_q  <= bwd_delim ? pos : seg_stop_cur;
				if (in_file && (pos_inc == {1'b0, size})) begin
					last_delim_q <= is_delim;
				end
				if (fwd_delim) begin
					line_count_q <= page_full ? '0 : lc_inc;
					if (page_full) begin
						page_begin_q <= pos_inc[PW-1:0];
					end
				end
				if (bwd_delim) begin
					fill_q <= fill_inc;
				end
			end
		end else if (cmd.emit_entry) begin
			if (status.last_entry) begin
				fill_q <= '0;
			end else begin
				rd_idx_q <= rd_idx_q + FW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			seg_mem[fill_q[AW-1:0]] <= mem_wdata;
		end
		rd_data_q <= seg_mem[rd_idx_q[AW-1:0]];
	end

endmodule

// ===== rtl/core/delimiter_line_pager_unit.sv =====
// Top level of the delimiter line pager: splits a byte stream into pages of lines.
//
// Channel   Dir  Handshake           Payload
// s_*       in   s_tvalid/s_tready   tdata: byte_value, byte_pos; tuser: opcode
// m_*       out  m_tvalid/m_tready   tdata: piece_start, piece_length; tlast: page_end
// cfg_*     in   cfg_valid/cfg_ready cfg_index selects the register, cfg_data its value
//
// A data beat that starts no flush, or a forward end of scan, leaves the block ready again
// on the next cycle as long as the two-entry result queue has a free slot.
// A backward flush reads the segment store through its single registered read port; each
// segment goes through S_FL_READ and S_FL_EMIT in turn, and s_tready stays low throughout.
// Reset is asynchronous and active low; it loads the register defaults and empties the
// scan state and the result queue, while the segment store contents stay undefined.
// A stalled m_tready holds results in the queue and, once it is full, holds off input.
module delimiter_line_pager_unit #(
	parameter int MAX_PAGE_LINES = 64,
	parameter int POS_BITS       = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [7:0] byte_value, [39:8] byte_pos
	input  logic [0:0]  s_tuser,   // [0] opcode (0 data byte, 1 end of scan)
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [31:0] piece_start, [63:32] piece_length
	output logic        m_tlast,   // page_end
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	dlp_pkg::ctrl_cmd_t  cmd;
	dlp_pkg::dp_status_t status;
	dlp_pkg::piece_t     push_data;
	dlp_pkg::piece_t     out_data;
	logic                push;
	logic                q_full;

	// Registers may be written at any cycle; a write applies from the next beat on.
	assign cfg_ready = 1'b1;

	dlp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.q_full   (q_full),
		.status   (status),
		.cmd      (cmd)
	);

	dlp_datapath #(
		.MAX_PAGE_LINES (MAX_PAGE_LINES),
		.POS_BITS       (POS_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_opcode (s_tuser[0]),
		.in_byte   (s_tdata[7:0]),
		.in_pos    (s_tdata[39:8]),
		.cmd       (cmd),
		.status    (status),
		.push      (push),
		.push_data (push_data)
	);

	// Each beat from the core becomes one output beat, in order.
	dlp_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_data)
	);

	assign m_tdata = {out_data.length, out_data.start};
	assign m_tlast = out_data.page_end;

endmodule

// ===== verif/delimiter_line_pager_unit_test.sv =====
// Self-checking testbench for the delimiter line pager: directed table, then random scans.
`timescale 1ns / 1ps

module delimiter_line_pager_unit_test;

	// Upper bound on the whole run. It covers every input beat raising a full
	// 64-piece backward flush, with the receiver stalled most of the time.
	localparam int CYCLE_LIMIT   = 400000;
	// Idle margin kept after the last expected piece before any register write.
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_BEATS  = 100;
	localparam int SEG_SLOTS     = 64;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;   // [7:0] byte_value, [39:8] byte_pos
	logic [0:0]  s_tuser = '0;   // [0] opcode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;        // [31:0] piece_start, [63:32] piece_length
	logic        m_tlast;        // page_end
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	delimiter_line_pager_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the register file, as the block should hold it.
	logic [6:0]  lines_reg = dlp_pkg::PAGE_LINES_RST;
	logic [7:0]  delim_reg = dlp_pkg::DELIMITER_RST;
	logic        backward_reg = 1'b0;
	logic [31:0] file_len_reg = '0;

	// Shadow copy of the scan state.
	logic [6:0]  lines_seen;
	logic [31:0] page_from;
	logic        tail_is_delim;
	logic [31:0] seg_upper;
	logic [31:0] seg_first [SEG_SLOTS];
	logic [31:0] seg_last [SEG_SLOTS];
	int          seg_count;
	bit          scan_live;

	// Pieces the block still owes us, oldest first.
	dlp_pkg::piece_t due_pieces [$];
	dlp_pkg::piece_t head_piece;

	int errors = 0;
	int pieces_checked = 0;
	int live_beats = 0;
	int cycles = 0;
	int idle_pct = 0;
	int stall_pct = 0;

	// Directed stimulus: one row is either a register write or an input beat.
	// A beat with a typed expectation replaces what the predictor would give.
	typedef struct {
		bit              is_cfg;
		logic [1:0]      idx;
		logic [31:0]     data;
		logic            op;
		logic [7:0]      val;
		logic [31:0]     pos;
		bit              typed;
		dlp_pkg::piece_t want;
	} script_row_t;

	script_row_t script [$];

	function automatic void add_reg(input logic [1:0] idx, input logic [31:0] data);
		script_row_t row;
		row = '{is_cfg: 1'b1, idx: idx, data: data, op: dlp_pkg::OP_DATA, val: '0,
			pos: '0, typed: 1'b0, want: '0};
		script.push_back(row);
	endfunction

	function automatic void add_beat(input logic op, input logic [7:0] val,
			input logic [31:0] pos);
		script_row_t row;
		row = '{is_cfg: 1'b0, idx: '0, data: '0, op: op, val: val, pos: pos,
			typed: 1'b0, want: '0};
		script.push_back(row);
	endfunction

	// End of scan whose single closing piece is obvious from the rules.
	function automatic void add_final(input logic [31:0] start, input logic [31:0] len);
		script_row_t row;
		row = '{is_cfg: 1'b0, idx: '0, data: '0, op: dlp_pkg::OP_EOS, val: '0, pos: '0,
			typed: 1'b1, want: '{page_end: 1'b1, length: len, start: start}};
		script.push_back(row);
	endfunction

	// Page size in effect: zero counts as one, anything above the store depth saturates.
	function automatic int page_size();
		int n;
		n = lines_reg;
		if (n == 0)
			n = 1;
		if (n > SEG_SLOTS)
			n = SEG_SLOTS;
		return n;
	endfunction

	function automatic void emit_piece(input logic [31:0] start, input logic [31:0] len,
			input logic last);
		dlp_pkg::piece_t p;
		p.start = start;
		p.length = len;
		p.page_end = last;
		due_pieces.push_back(p);
	endfunction

	// Drain the buffered backward segments in the order they were stored.
	function automatic void flush_segments();
		for (int i = 0; i < seg_count; i++)
			emit_piece(seg_first[i],
				(seg_last[i] >= seg_first[i]) ? seg_last[i] - seg_first[i] : 32'd0,
				i + 1 == seg_count);
		seg_count = 0;
	endfunction

	function automatic void restart_scan();
		lines_seen = '0;
		page_from = '0;
		tail_is_delim = 1'b0;
		seg_upper = file_len_reg;
		seg_count = 0;
		scan_live = 1'b0;
	endfunction

	function automatic void apply_reg(input logic [1:0] idx, input logic [31:0] data);
		case (idx)
			dlp_pkg::REG_PAGE_LINES:    lines_reg = data[6:0];
			dlp_pkg::REG_DELIMITER:     delim_reg = data[7:0];
			dlp_pkg::REG_BACKWARD_MODE: backward_reg = data[0];
			dlp_pkg::REG_FILE_LENGTH:   file_len_reg = data;
			default: ;
		endcase
	endfunction

	// Works out the pieces that one accepted input beat causes.
	function automatic void predict_pages(input logic op, input logic [7:0] val,
			input logic [31:0] pos);
		int  n;
		bit  hit;
		n = page_size();
		if (!scan_live) begin
			seg_upper = file_len_reg;
			scan_live = 1'b1;
		end
		if (op == dlp_pkg::OP_DATA) begin
			hit = (val == delim_reg);
			if (pos >= file_len_reg)
				return;
			if ({1'b0, pos} + 33'd1 == {1'b0, file_len_reg})
				tail_is_delim = hit;
			if (!hit)
				return;
			if (!backward_reg) begin
				lines_seen = lines_seen + 7'd1;
				if (lines_seen >= n) begin
					if (pos >= page_from)
						emit_piece(page_from, pos - page_from, 1'b1);
					page_from = pos + 32'd1;
					lines_seen = '0;
				end
			end else begin
				if (seg_count < SEG_SLOTS) begin
					seg_first[seg_count] = pos + 32'd1;
					seg_last[seg_count] = seg_upper;
					seg_count++;
				end
				seg_upper = pos;
				if (seg_count >= n)
					flush_segments();
			end
			return;
		end
		// End of scan.
		if (file_len_reg == 0) begin
			emit_piece('0, '0, 1'b1);
		end else if (!backward_reg) begin
			if (page_from < file_len_reg)
				emit_piece(page_from, file_len_reg - page_from, 1'b1);
			else if (tail_is_delim)
				emit_piece('0, '0, 1'b1);
		end else begin
			if (seg_count < SEG_SLOTS) begin
				seg_first[seg_count] = '0;
				seg_last[seg_count] = seg_upper;
				seg_count++;
			end
			flush_segments();
		end
		restart_scan();
	endfunction

	// Lower both request lines and wait until every owed piece has arrived,
	// then leave the block idle for the settle margin.
	task automatic settle_block();
		s_tvalid <= 1'b0;
		cfg_valid <= 1'b0;
		while (due_pieces.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// cfg_valid stays high after the beat, so back-to-back writes need not lower
	// it in between; the next input beat or settle lowers it.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		apply_reg(idx, data);
	endtask

	// Offers one input beat, with a random gap in front of it, and predicts its
	// pieces at the edge where it is taken. s_tvalid is left high so that the
	// next beat can follow at once.
	task automatic push_beat(input logic op, input logic [7:0] val, input logic [31:0] pos,
			input bit typed, input dlp_pkg::piece_t want);
		int gap;
		int held;
		gap = 0;
		if (cfg_valid)
			cfg_valid <= 1'b0;
		while (gap < 12 && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {pos, val};
		s_tuser <= op;
		do
			@(posedge clk);
		while (!s_tready);
		live_beats++;
		held = due_pieces.size();
		predict_pages(op, val, pos);
		if (typed) begin
			while (due_pieces.size() > held)
				void'(due_pieces.pop_back());
			due_pieces.push_back(want);
		end
	endtask

	// One random scan: fresh registers, then a mostly well-formed byte run in the
	// order the mode wants, salted with stray and misplaced bytes, then end of scan.
	task automatic random_scan(input int scan_no);
		logic [6:0]      lines;
		logic [7:0]      delim;
		logic            backward;
		logic [31:0]     flen;
		logic [31:0]     lo;
		logic [31:0]     pos;
		logic [7:0]      val;
		int              span;
		int              run_len;
		int              pick;
		dlp_pkg::piece_t none;
		none = '0;
		case ((scan_no / 5) % 4)
			0: begin idle_pct = 0;  stall_pct = 0;  end
			1: begin idle_pct = 56; stall_pct = 0;  end
			2: begin idle_pct = 0;  stall_pct = 56; end
			default: begin idle_pct = 11; stall_pct = 11; end
		endcase
		pick = $urandom_range(9);
		case (pick)
			0: lines = 7'd0;
			1: lines = 7'h7F;
			2: lines = 7'd64;
			3, 4, 5: lines = 7'($urandom_range(1, 3));
			default: lines = 7'($urandom_range(1, 8));
		endcase
		delim = ($urandom_range(3) == 0) ? dlp_pkg::DELIMITER_RST : 8'($urandom_range(255));
		backward = 1'($urandom_range(1));
		span = $urandom_range(1, 40);
		pick = $urandom_range(9);
		if (pick == 0)
			flen = '0;
		else if (pick == 1)
			flen = 32'hFFFF_FFFF - 32'($urandom_range(40));
		else
			flen = 32'(span);
		run_len = (flen < 32'(span)) ? int'(flen) : span;
		lo = flen - 32'(run_len);

		settle_block();
		write_reg(dlp_pkg::REG_PAGE_LINES, {25'($urandom()), lines});
		write_reg(dlp_pkg::REG_DELIMITER, {24'($urandom()), delim});
		write_reg(dlp_pkg::REG_BACKWARD_MODE, {31'($urandom()), backward});
		write_reg(dlp_pkg::REG_FILE_LENGTH, flen);

		for (int k = 0; k < run_len; k++) begin
			// Once in the run the sender holds off mid scan until all owed
			// pieces are in.
			if (scan_no == 2 && k == run_len / 2)
				settle_block();
			// A truncated scan now and then.
			if ($urandom_range(24) == 0)
				break;
			pos = backward ? flen - 32'd1 - 32'(k) : lo + 32'(k);
			val = ($urandom_range(2) == 0) ? delim : 8'($urandom_range(255));
			pick = $urandom_range(29);
			if (pick < 2)
				push_beat(dlp_pkg::OP_DATA, 8'($urandom_range(255)), $urandom(), 1'b0,
					none);
			else if (pick < 4)
				pos = lo + 32'($urandom_range(run_len - 1));
			push_beat(dlp_pkg::OP_DATA, val, pos, 1'b0, none);
		end
		push_beat(dlp_pkg::OP_EOS, 8'($urandom_range(255)), $urandom(), 1'b0, none);
	endtask

	// Result side: random back-pressure per the current idling phase.
	always @(posedge clk)
		m_tready <= (stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= stall_pct);

	// Every piece the block hands over is matched against the oldest one owed.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (due_pieces.size() == 0) begin
				errors++;
				$display("%0t: unexpected piece start %h length %h page_end %b",
					$time, m_tdata[31:0], m_tdata[63:32], m_tlast);
			end else begin
				head_piece = due_pieces.pop_front();
				pieces_checked++;
				if (m_tdata[31:0] !== head_piece.start) begin
					errors++;
					$display("%0t: piece_start mismatch, expected %h actual %h",
						$time, head_piece.start, m_tdata[31:0]);
				end
				if (m_tdata[63:32] !== head_piece.length) begin
					errors++;
					$display("%0t: piece_length mismatch, expected %h actual %h",
						$time, head_piece.length, m_tdata[63:32]);
				end
				if (m_tlast !== head_piece.page_end) begin
					errors++;
					$display("%0t: page_end mismatch, expected %b actual %b",
						$time, head_piece.page_end, m_tlast);
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Watchdog expired with %0d pieces still owed", due_pieces.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int base_beats;
		int scan_no;
		restart_scan();

		// Empty file straight out of reset: one empty page.
		add_final(32'd0, 32'd0);

		// Forward, one line per page (zero acts as one), five-byte file.
		add_reg(dlp_pkg::REG_PAGE_LINES, 32'd0);
		add_reg(dlp_pkg::REG_FILE_LENGTH, 32'd5);
		add_beat(dlp_pkg::OP_DATA, 8'h61, 32'd0);
		add_beat(dlp_pkg::OP_DATA, dlp_pkg::DELIMITER_RST, 32'd1);
		add_beat(dlp_pkg::OP_DATA, dlp_pkg::DELIMITER_RST, 32'd2);  // empty line
		add_beat(dlp_pkg::OP_DATA, 8'hFF, 32'd3);
		add_beat(dlp_pkg::OP_DATA, dlp_pkg::DELIMITER_RST, 32'd4);  // last byte is a delimiter
		add_beat(dlp_pkg::OP_DATA, dlp_pkg::DELIMITER_RST, 32'd7);  // beyond the file, ignored
		add_final(32'd0, 32'd0);                                     // empty tail piece

		// Largest page count saturates; delimiter zero; largest file. The last
		// byte is a delimiter, the byte past the end is dropped, and the tail
		// piece spans the whole file.
		add_reg(dlp_pkg::REG_PAGE_LINES, 32'hFFFF_FFFF);
		add_reg(dlp_pkg::REG_DELIMITER, 32'd0);
		add_reg(dlp_pkg::REG_FILE_LENGTH, 32'hFFFF_FFFF);
		add_beat(dlp_pkg::OP_DATA, 8'h00, 32'hFFFF_FFFE);
		add_beat(dlp_pkg::OP_DATA, 8'h00, 32'hFFFF_FFFF);
		add_final(32'd0, 32'hFFFF_FFFF);

		// Page size lowered in the middle of a scan takes effect at once.
		add_reg(dlp_pkg::REG_PAGE_LINES, 32'd3);
		add_reg(dlp_pkg::REG_DELIMITER, {24'd0, dlp_pkg::DELIMITER_RST});
		add_reg(dlp_pkg::REG_FILE_LENGTH, 32'd20);
		add_beat(dlp_pkg::OP_DATA, dlp_pkg::DELIMITER_RST, 32'd2);
		add_beat(dlp_pkg::OP_DATA, dlp_pkg::DELIMITER_RST, 32'd4);
		add_reg(dlp_pkg::REG_PAGE_LINES, 32'd2);
		add_beat(dlp_pkg::OP_DATA, dlp_pkg::DELIMITER_RST, 32'd6);
		add_beat(dlp_pkg::OP_EOS, 8'h00, 32'd0);

		// Backward, two lines per page, bytes in falling order.
		add_reg(dlp_pkg::REG_BACKWARD_MODE, 32'd1);
		add_reg(dlp_pkg::REG_FILE_LENGTH, 32'd6);
		add_beat(dlp_pkg::OP_DATA, 8'h78, 32'd5);
		add_beat(dlp_pkg::OP_DATA, dlp_pkg::DELIMITER_RST, 32'd4);
		add_beat(dlp_pkg::OP_DATA, 8'h79, 32'd3);
		add_beat(dlp_pkg::OP_DATA, dlp_pkg::DELIMITER_RST, 32'd2);
		add_beat(dlp_pkg::OP_DATA, dlp_pkg::DELIMITER_RST, 32'd1);
		add_beat(dlp_pkg::OP_EOS, 8'hFF, 32'hFFFF_FFFF);

		// Backward bytes out of order: a segment that starts past its stop.
		add_beat(dlp_pkg::OP_DATA, dlp_pkg::DELIMITER_RST, 32'd1);
		add_beat(dlp_pkg::OP_DATA, dlp_pkg::DELIMITER_RST, 32'd4);
		add_beat(dlp_pkg::OP_EOS, 8'h00, 32'd0);

		// Empty file in backward mode.
		add_reg(dlp_pkg::REG_FILE_LENGTH, 32'd0);
		add_final(32'd0, 32'd0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].is_cfg) begin
				settle_block();
				write_reg(script[i].idx, script[i].data);
			end else begin
				push_beat(script[i].op, script[i].val, script[i].pos,
					script[i].typed, script[i].want);
			end
		end

		base_beats = live_beats;
		scan_no = 0;
		while (live_beats - base_beats < RANDOM_BEATS && scan_no < 300) begin
			random_scan(scan_no);
			scan_no++;
		end

		settle_block();
		repeat (20) @(posedge clk);

		$display("Covered %0d directed rows and %0d random scans in both modes.",
			script.size(), scan_no);
		$display("%0d input beats taken, %0d pieces compared, %0d mismatches.",
			live_beats, pieces_checked, errors);
		if (errors == 0 && due_pieces.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
